// ===== sv/arfs_pkg.sv =====
// Shared types, codes and sizes for the acknowledged frame sender.
package arfs_pkg;

    localparam int MAX_LEN = 32;
    localparam int LEN_W   = 6;
    localparam int ADDR_W  = $clog2(MAX_LEN);

    localparam logic [7:0] START_LEN   = 8'h11;
    localparam logic [7:0] START_NOLEN = 8'h12;

    localparam logic [1:0] OP_PAYLOAD = 2'd0;
    localparam logic [1:0] OP_REPLY   = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [2:0] ST_SENDING  = 3'd0;
    localparam logic [2:0] ST_ACKED    = 3'd1;
    localparam logic [2:0] ST_RESENT   = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_AWAIT   = 2'd2;

    localparam logic [2:0] SEL_NONE  = 3'd0;
    localparam logic [2:0] SEL_BYTE  = 3'd1;
    localparam logic [2:0] SEL_START = 3'd2;
    localparam logic [2:0] SEL_LEN   = 3'd3;
    localparam logic [2:0] SEL_MEM   = 3'd4;
    localparam logic [2:0] SEL_SUM   = 3'd5;

    localparam logic [0:0] REG_FRAMED = 1'b0;
    localparam logic [0:0] REG_ACK    = 1'b1;

    typedef struct packed {
        logic       item_load;
        logic       emit;
        logic [2:0] sel;
        logic [2:0] status;
        logic       last;
        logic       start_frame;
        logic       pay_write;
        logic       set_await;
        logic       ack_clear;
        logic       rd_clear;
        logic       rd_step;
    } t_ctl_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] phase;
        logic       framed;
        logic       len_ok;
        logic       is_ack;
        logic       kind;
        logic       pay_done;
        logic       rd_last;
        logic       emit_ok;
    } t_dp_stat;

endpackage

// ===== sv/arfs_ctrl.sv =====
// Sequencer that walks each item through the words it produces.
module arfs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  arfs_pkg::t_dp_stat  i_stat,
    output arfs_pkg::t_ctl_cmd  o_cmd
);
    import arfs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_HEAD0  = 3'd2;
    localparam logic [2:0] S_HEAD1  = 3'd3;
    localparam logic [2:0] S_PAY    = 3'd4;
    localparam logic [2:0] S_RDATA  = 3'd5;
    localparam logic [2:0] S_SUM    = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_resend, n_resend;
    logic [2:0] w_frame_st;

    assign w_frame_st = r_resend ? ST_RESENT : ST_SENDING;
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resend <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resend <= n_resend;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_resend = r_resend;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state         = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.op == OP_PAYLOAD) begin
                    if (i_stat.phase == PH_AWAIT) begin
                        o_cmd.status = ST_REJECTED;
                        o_cmd.emit   = i_stat.emit_ok;
                    end else if (!i_stat.framed) begin
                        o_cmd.sel    = SEL_BYTE;
                        o_cmd.status = ST_SENDING;
                        o_cmd.emit   = i_stat.emit_ok;
                    end else if (i_stat.phase != PH_COLLECT) begin
                        if (!i_stat.len_ok) begin
                            o_cmd.status = ST_REJECTED;
                            o_cmd.emit   = i_stat.emit_ok;
                        end else begin
                            o_cmd.start_frame = 1'b1;
                            n_resend          = 1'b0;
                            n_state           = S_HEAD0;
                        end
                    end else begin
                        n_resend = 1'b0;
                        n_state  = S_PAY;
                    end
                end else if (i_stat.op == OP_REPLY || i_stat.op == OP_TIMEOUT) begin
                    if (i_stat.phase != PH_AWAIT) begin
                        o_cmd.status = ST_IGNORED;
                        o_cmd.emit   = i_stat.emit_ok;
                    end else if (i_stat.op == OP_REPLY && i_stat.is_ack) begin
                        o_cmd.status    = ST_ACKED;
                        o_cmd.emit      = i_stat.emit_ok;
                        o_cmd.ack_clear = i_stat.emit_ok;
                    end else begin
                        o_cmd.rd_clear = 1'b1;
                        n_resend       = 1'b1;
                        n_state        = S_HEAD0;
                    end
                end else begin
                    o_cmd.status = ST_REJECTED;
                    o_cmd.emit   = i_stat.emit_ok;
                end
                if (o_cmd.emit) begin
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_HEAD0: begin
                o_cmd.sel    = SEL_START;
                o_cmd.status = w_frame_st;
                if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (!i_stat.kind) begin
                        n_state = S_HEAD1;
                    end else begin
                        n_state = r_resend ? S_RDATA : S_PAY;
                    end
                end
            end
            S_HEAD1: begin
                o_cmd.sel    = SEL_LEN;
                o_cmd.status = w_frame_st;
                if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = r_resend ? S_RDATA : S_PAY;
                end
            end
            S_PAY: begin
                o_cmd.sel    = SEL_BYTE;
                o_cmd.status = ST_SENDING;
                if (i_stat.emit_ok) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.pay_write = 1'b1;
                    if (i_stat.pay_done) begin
                        o_cmd.set_await = 1'b1;
                        n_state         = S_SUM;
                    end else begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_RDATA: begin
                o_cmd.sel    = SEL_MEM;
                o_cmd.status = ST_RESENT;
                if (i_stat.emit_ok) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.rd_step = 1'b1;
                    if (i_stat.rd_last) begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                o_cmd.sel    = SEL_SUM;
                o_cmd.status = w_frame_st;
                if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/arfs_dp.sv =====
// Frame state, payload buffer, checksum, register file and output word register.
module arfs_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_byte,
    input  logic [5:0]          i_len,
    input  logic                i_kind,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_out_txv,
    output logic [7:0]          o_out_byte,
    output logic [2:0]          o_out_status,
    output logic                o_out_last,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata,
    output logic [31:0]         o_cfg_rdata,
    input  arfs_pkg::t_ctl_cmd  i_cmd,
    output arfs_pkg::t_dp_stat  o_stat
);
    import arfs_pkg::*;

    logic [7:0]        r_mem [MAX_LEN];
    logic [7:0]        r_rd_data;
    logic [LEN_W-1:0]  r_rd_idx, n_rd_idx;

    logic [1:0]        r_op;
    logic [7:0]        r_byte;
    logic [LEN_W-1:0]  r_len;
    logic              r_kind;

    logic [1:0]        r_phase;
    logic [LEN_W-1:0]  r_taken;
    logic [LEN_W-1:0]  r_lat_len;
    logic              r_lat_kind;
    logic [7:0]        r_sum;

    logic              r_framed;
    logic [7:0]        r_ack;

    logic              r_out_valid;
    logic              r_out_txv;
    logic [7:0]        r_out_byte;
    logic [2:0]        r_out_status;
    logic              r_out_last;

    logic [7:0]        w_word;
    logic              w_emit_ok;

    assign w_emit_ok = !r_out_valid || i_out_ready;

    assign o_stat.op       = r_op;
    assign o_stat.phase    = r_phase;
    assign o_stat.framed   = r_framed;
    assign o_stat.len_ok   = (r_len != '0) && (r_len <= LEN_W'(MAX_LEN));
    assign o_stat.is_ack   = (r_byte == r_ack);
    assign o_stat.kind     = r_lat_kind;
    assign o_stat.pay_done = (r_taken + LEN_W'(1)) >= r_lat_len;
    assign o_stat.rd_last  = (r_rd_idx + LEN_W'(1)) == r_taken;
    assign o_stat.emit_ok  = w_emit_ok;

    assign o_cfg_rdata = (i_cfg_idx == REG_FRAMED) ? {31'd0, r_framed} : {24'd0, r_ack};

    always_comb begin
        case (i_cmd.sel)
            SEL_BYTE:  w_word = r_byte;
            SEL_START: w_word = r_lat_kind ? START_NOLEN : START_LEN;
            SEL_LEN:   w_word = {{(8 - LEN_W){1'b0}}, r_lat_len};
            SEL_MEM:   w_word = r_rd_data;
            SEL_SUM:   w_word = r_sum;
            default:   w_word = 8'd0;
        endcase
    end

    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.rd_clear) begin
            n_rd_idx = '0;
        end else if (i_cmd.rd_step) begin
            n_rd_idx = r_rd_idx + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_write && (r_taken < LEN_W'(MAX_LEN))) begin
            r_mem[r_taken[ADDR_W-1:0]] <= r_byte;
        end
        r_rd_data <= r_mem[n_rd_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_op   <= i_op;
            r_byte <= i_byte;
            r_len  <= i_len;
            r_kind <= i_kind;
        end
        if (i_cmd.emit) begin
            r_out_txv    <= (i_cmd.sel != SEL_NONE);
            r_out_byte   <= w_word;
            r_out_status <= i_cmd.status;
            r_out_last   <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_taken     <= '0;
            r_lat_len   <= '0;
            r_lat_kind  <= 1'b0;
            r_sum       <= 8'd0;
            r_rd_idx    <= '0;
            r_framed    <= 1'b1;
            r_ack       <= 8'd6;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_idx <= n_rd_idx;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAMED) begin
                    r_framed <= i_cfg_wdata[0];
                end else begin
                    r_ack <= i_cfg_wdata[7:0];
                end
            end
            if (i_cmd.start_frame) begin
                r_lat_len  <= r_len;
                r_lat_kind <= r_kind;
                r_taken    <= '0;
                r_sum      <= r_kind ? START_NOLEN : START_LEN + {{(8 - LEN_W){1'b0}}, r_len};
                r_phase    <= PH_COLLECT;
            end
            if (i_cmd.pay_write) begin
                r_taken <= r_taken + LEN_W'(1);
                r_sum   <= r_sum + r_byte;
            end
            if (i_cmd.set_await) begin
                r_phase <= PH_AWAIT;
            end
            if (i_cmd.ack_clear) begin
                r_phase <= PH_IDLE;
                r_taken <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_txv    = r_out_txv;
    assign o_out_byte   = r_out_byte;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

// ===== sv/ack_retry_frame_sender.sv =====
// Top level of the acknowledged frame sender: stream ports, register port, control and data.
// The accepted item is registered and decided on; a one-word result then goes straight into
// the output word register, while a frame byte or a resend moves on to the states that put
// out its words, one word per cycle while taken. A framed byte gives up to four words, a
// resend of N bytes N + 2 or N + 3; one item at a time, output stalls hold it.
// Synchronous active-low reset: phase idle, counts and checksum zero, framed on, ACK 6.
module ack_retry_frame_sender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // byte_value[7:0], frame_length[13:8], frame_kind[14], 0
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // tx_byte[7:0]
    output logic [3:0]  m_axis_tuser,  // tx_valid[0], status[3:1]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import arfs_pkg::*;

    t_ctl_cmd   w_cmd;
    t_dp_stat   w_stat;
    logic       w_txv;
    logic [2:0] w_status;

    assign pready = 1'b1;

    arfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    arfs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (s_axis_tuser),
        .i_byte       (s_axis_tdata[7:0]),
        .i_len        (s_axis_tdata[13:8]),
        .i_kind       (s_axis_tdata[14]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_txv    (w_txv),
        .o_out_byte   (m_axis_tdata),
        .o_out_status (w_status),
        .o_out_last   (m_axis_tlast),
        .i_cfg_we     (psel && penable && pwrite),
        .i_cfg_idx    (paddr[2:2]),
        .i_cfg_wdata  (pwdata),
        .o_cfg_rdata  (prdata),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat)
    );

    assign m_axis_tuser = {w_status, w_txv};

endmodule

// ===== sv/arfs_checker.sv =====
// Port-level checks for the acknowledged frame sender, bound to the top level.
module arfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import arfs_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("line byte nonzero on a word with nothing to send");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[3:1] == ST_ACKED || m_axis_tuser[3:1] == ST_REJECTED
            || m_axis_tuser[3:1] == ST_IGNORED) |-> m_axis_tlast)
        else $error("acknowledge, reject or ignore word not marked last");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in progress");

endmodule

bind ack_retry_frame_sender arfs_checker u_arfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
